// ===== rtl/core/sfle_pkg.sv =====
// Shared types, constants and codes for the squarefree set enumerator.
package sfle_pkg;

    localparam int POOL_DEPTH = 4096;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int MAX_SET    = 10;
    localparam int STACK_AW   = $clog2(MAX_SET);

    localparam int VAL_W   = 32;
    localparam int CNT_W   = 13;
    localparam int DEPTH_W = 4;

    localparam int IN_W  = 48;
    localparam int OUT_W = 72;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic {
        CFG_UPPER_BOUND = 1'b0,
        CFG_POOL_COUNT  = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_MUL,
        S_CMP,
        S_POP,
        S_POP_RD,
        S_NEWEST,
        S_NEWEST_RD
    } state_t;

    typedef struct packed {
        logic [POOL_AW-1:0] idx;
        logic [VAL_W-1:0]   prod;
    } stack_entry_t;

endpackage

// ===== rtl/core/sfle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sfle_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/squarefree_lex_enumerator.sv =====
// Squarefree enumerator: walks prime sets in lexicographic order below a bound.
// A load, restart, no-op, or advance after the end or on an empty pool goes straight to
// the newest-prime read and the result. An advance tries candidates in turn (RAM read, multiply,
// compare; an append that overshoots is retried as a replace) and re-reads the stack for each popped
// level but the one that empties the set. A new command is taken only once the result is registered.
// Reset (rst_n low, asynchronous) gives the empty set, n = 1, ended, bound 0, pool count 0.
module squarefree_lex_enumerator
    import sfle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // input stream
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,  // op[1:0], entry_index[13:2], entry_prime[45:14]
    // result stream
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,  // product_n[31:0], newest_prime[63:32],
                                            // set_size[67:64], moebius_negative[68],
                                            // at_end[69]
    // configuration writes
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [VAL_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [VAL_W-1:0]    bound_reg;
    logic [CNT_W-1:0]    pool_count_reg;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [VAL_W-1:0]    n_reg, n_next;
    logic                ended_reg, ended_next;
    logic [POOL_AW-1:0]  top_idx_reg, top_idx_next;   // pool index of the newest level's prime
    logic                out_valid_reg, out_valid_next;

    // payload, no reset
    logic [CNT_W-1:0]    cand_reg, cand_next;         // candidate pool index
    logic [DEPTH_W-1:0]  lvl_reg, lvl_next;           // level being tried
    logic [2*VAL_W-1:0]  prod_reg, prod_next;
    logic [OUT_W-1:0]    out_data_reg, out_data_next;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                pool_we, pool_re;
    logic [POOL_AW-1:0]  pool_waddr, pool_raddr;
    logic [VAL_W-1:0]    pool_wdata, pool_rdata;

    logic                stk_we, stk_re;
    logic [STACK_AW-1:0] stk_waddr, stk_raddr;
    stack_entry_t        stk_wdata, stk_rdata;
    logic [$bits(stack_entry_t)-1:0] stk_rdata_raw;

    sfle_ram #(
        .DEPTH (POOL_DEPTH),
        .WIDTH (VAL_W)
    ) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    sfle_ram #(
        .DEPTH (MAX_SET),
        .WIDTH ($bits(stack_entry_t))
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata_raw)
    );

    assign stk_rdata = stack_entry_t'(stk_rdata_raw);

    // ------------------------------------------------------------------
    // Shared decisions
    // ------------------------------------------------------------------
    logic               in_xfer;
    op_t                in_op;
    logic [CNT_W-1:0]   pool_cnt;      // pool_count saturated to the pool depth
    logic [CNT_W-1:0]   adv_cand;
    logic               adv_cand_ok;
    logic [CNT_W-1:0]   pop_cand;
    logic               pop_cand_ok;
    logic               prod_fits;
    logic               is_push;
    logic               out_free;
    logic [VAL_W-1:0]   mul_base;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_op         = op_t'(s_axis_tdata[1:0]);

    assign pool_cnt    = (pool_count_reg > CNT_W'(POOL_DEPTH)) ? CNT_W'(POOL_DEPTH)
                                                               : pool_count_reg;
    assign adv_cand    = CNT_W'(top_idx_reg) + CNT_W'(1);
    assign adv_cand_ok = adv_cand < pool_cnt;
    assign pop_cand    = CNT_W'(stk_rdata.idx) + CNT_W'(1);
    assign pop_cand_ok = pop_cand < pool_cnt;

    // the product is below the bound only when its upper half is clear
    assign prod_fits = (prod_reg[2*VAL_W-1:VAL_W] == '0) && (prod_reg[VAL_W-1:0] < bound_reg);
    assign is_push   = (lvl_reg == depth_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;

    // level zero has no prefix, so its product is the prime alone
    assign mul_base = (lvl_reg == '0) ? VAL_W'(1) : stk_rdata.prod;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_op)
                        OP_ADVANCE:
                        begin
                            if (ended_reg)
                            begin
                                state_next = S_NEWEST;
                            end
                            else if (depth_reg == '0)
                            begin
                                state_next = (pool_cnt == '0) ? S_NEWEST : S_FETCH;
                            end
                            else
                            begin
                                state_next = adv_cand_ok ? S_FETCH : S_POP;
                            end
                        end
                        default:
                        begin
                            state_next = S_NEWEST;
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (prod_fits)
                begin
                    state_next = S_NEWEST;
                end
                else if (is_push)
                begin
                    state_next = (depth_reg == '0) ? S_NEWEST : S_FETCH;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                state_next = (depth_reg == DEPTH_W'(1)) ? S_NEWEST : S_POP_RD;
            end
            S_POP_RD:
            begin
                state_next = pop_cand_ok ? S_FETCH : S_POP;
            end
            S_NEWEST:
            begin
                state_next = S_NEWEST_RD;
            end
            S_NEWEST_RD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        depth_next    = depth_reg;
        n_next        = n_reg;
        ended_next    = ended_reg;
        top_idx_next  = top_idx_reg;
        cand_next     = cand_reg;
        lvl_next      = lvl_reg;
        prod_next     = prod_reg;
        out_data_next = out_data_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;

        pool_we    = 1'b0;
        pool_waddr = s_axis_tdata[13:2];
        pool_wdata = s_axis_tdata[45:14];
        pool_re    = 1'b0;
        pool_raddr = cand_reg[POOL_AW-1:0];

        stk_we     = 1'b0;
        stk_waddr  = lvl_reg;
        stk_wdata  = '{idx: cand_reg[POOL_AW-1:0], prod: prod_reg[VAL_W-1:0]};
        stk_re     = 1'b0;
        stk_raddr  = (lvl_reg == '0) ? '0 : lvl_reg - STACK_AW'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (in_op)
                        OP_LOAD:
                        begin
                            pool_we = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            depth_next = '0;
                            n_next     = VAL_W'(1);
                            ended_next = (bound_reg <= VAL_W'(1));
                        end
                        OP_ADVANCE:
                        begin
                            if (!ended_reg)
                            begin
                                if (depth_reg == '0)
                                begin
                                    // empty pool ends the walk, else try the first prime
                                    if (pool_cnt == '0)
                                    begin
                                        ended_next = 1'b1;
                                    end
                                    lvl_next  = '0;
                                    cand_next = '0;
                                end
                                else if (adv_cand_ok)
                                begin
                                    // append when there is room, otherwise replace
                                    cand_next = adv_cand;
                                    lvl_next  = (depth_reg < DEPTH_W'(MAX_SET))
                                                ? depth_reg : depth_reg - DEPTH_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                // read the candidate prime and the prefix product together
                pool_re = 1'b1;
                stk_re  = 1'b1;
            end
            S_MUL:
            begin
                prod_next = (2*VAL_W)'(mul_base) * (2*VAL_W)'(pool_rdata);
            end
            S_CMP:
            begin
                if (prod_fits)
                begin
                    stk_we       = 1'b1;
                    depth_next   = lvl_reg + DEPTH_W'(1);
                    n_next       = prod_reg[VAL_W-1:0];
                    top_idx_next = cand_reg[POOL_AW-1:0];
                end
                else if (is_push)
                begin
                    if (depth_reg == '0)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        // append overshot: retry the same prime in place of the newest
                        lvl_next = depth_reg - DEPTH_W'(1);
                    end
                end
            end
            S_POP:
            begin
                depth_next = depth_reg - DEPTH_W'(1);
                if (depth_reg == DEPTH_W'(1))
                begin
                    ended_next = 1'b1;
                    n_next     = VAL_W'(1);
                end
                else
                begin
                    // fetch the level that becomes the newest
                    stk_re    = 1'b1;
                    stk_raddr = STACK_AW'(depth_reg - DEPTH_W'(2));
                end
            end
            S_POP_RD:
            begin
                top_idx_next = stk_rdata.idx;
                cand_next    = pop_cand;
                lvl_next     = depth_reg - DEPTH_W'(1);
            end
            S_NEWEST:
            begin
                pool_re    = 1'b1;
                pool_raddr = top_idx_reg;
            end
            S_NEWEST_RD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00,
                                      ended_reg,
                                      depth_reg[0],
                                      depth_reg,
                                      (depth_reg == '0) ? VAL_W'(0) : pool_rdata,
                                      n_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bound_reg      <= '0;
            pool_count_reg <= '0;
            depth_reg      <= '0;
            n_reg          <= VAL_W'(1);
            ended_reg      <= 1'b1;
            top_idx_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            n_reg         <= n_next;
            ended_reg     <= ended_next;
            top_idx_reg   <= top_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_UPPER_BOUND: bound_reg      <= cfg_data;
                    CFG_POOL_COUNT:  pool_count_reg <= cfg_data[CNT_W-1:0];
                    default:         bound_reg      <= bound_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        lvl_reg      <= lvl_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
